FILE: sv/ow_pkg.sv
// ----------------------------------------------------------------------------
// ow_pkg
// shared types and constants of the one-wire bus master
// ----------------------------------------------------------------------------
package ow_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int TCNT_W        = 12;
  localparam int BIDX_W        = $clog2(BITS_PER_BYTE);

  // operation phases, equal to the command codes that start them
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RESET = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;
  localparam logic [1:0] PH_READ  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [2:0] REG_SLOT          = 3'd3;
  localparam logic [2:0] REG_WRITE_ONE_LOW = 3'd4;
  localparam logic [2:0] REG_WRITE_ZERO_LOW = 3'd5;
  localparam logic [2:0] REG_READ_LOW      = 3'd6;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd7;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [9:0] presence_wait_us;
    logic [9:0] reset_tail_us;
    logic [7:0] slot_us;
    logic [7:0] write_one_low_us;
    logic [7:0] write_zero_low_us;
    logic [7:0] read_low_us;
    logic [7:0] read_sample_us;
  } ow_cfg_t;

  typedef struct packed {
    logic       pull_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
  } ow_result_t;

endpackage

FILE: sv/ow_apb_regs.sv
// ----------------------------------------------------------------------------
// ow_apb_regs
// timing registers of the one-wire master behind an apb-style port
// ----------------------------------------------------------------------------
module ow_apb_regs (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output ow_pkg::ow_cfg_t cfg
);
  import ow_pkg::*;

  ow_cfg_t    cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_us      <= 10'd480;
      cfg_r.presence_wait_us  <= 10'd70;
      cfg_r.reset_tail_us     <= 10'd410;
      cfg_r.slot_us           <= 8'd70;
      cfg_r.write_one_low_us  <= 8'd6;
      cfg_r.write_zero_low_us <= 8'd60;
      cfg_r.read_low_us       <= 8'd6;
      cfg_r.read_sample_us    <= 8'd9;
    end else if (wr_en) begin
      unique case (idx)
        REG_RESET_LOW:      cfg_r.reset_low_us      <= pwdata[9:0];
        REG_PRESENCE_WAIT:  cfg_r.presence_wait_us  <= pwdata[9:0];
        REG_RESET_TAIL:     cfg_r.reset_tail_us     <= pwdata[9:0];
        REG_SLOT:           cfg_r.slot_us           <= pwdata[7:0];
        REG_WRITE_ONE_LOW:  cfg_r.write_one_low_us  <= pwdata[7:0];
        REG_WRITE_ZERO_LOW: cfg_r.write_zero_low_us <= pwdata[7:0];
        REG_READ_LOW:       cfg_r.read_low_us       <= pwdata[7:0];
        REG_READ_SAMPLE:    cfg_r.read_sample_us    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RESET_LOW:      prdata = {22'd0, cfg_r.reset_low_us};
      REG_PRESENCE_WAIT:  prdata = {22'd0, cfg_r.presence_wait_us};
      REG_RESET_TAIL:     prdata = {22'd0, cfg_r.reset_tail_us};
      REG_SLOT:           prdata = {24'd0, cfg_r.slot_us};
      REG_WRITE_ONE_LOW:  prdata = {24'd0, cfg_r.write_one_low_us};
      REG_WRITE_ZERO_LOW: prdata = {24'd0, cfg_r.write_zero_low_us};
      REG_READ_LOW:       prdata = {24'd0, cfg_r.read_low_us};
      REG_READ_SAMPLE:    prdata = {24'd0, cfg_r.read_sample_us};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

FILE: sv/ow_engine.sv
// ----------------------------------------------------------------------------
// ow_engine
// per-tick reset / write / read slot sequencer and its state registers
// ----------------------------------------------------------------------------
module ow_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic [1:0]         action,
  input  logic [7:0]         tx_byte,
  input  logic               line_in,
  input  ow_pkg::ow_cfg_t    cfg,
  output ow_pkg::ow_result_t res
);
  import ow_pkg::*;

  logic [1:0]        phase_r, phase_nxt;
  logic [TCNT_W-1:0] tcnt_r, tcnt_nxt;
  logic [BIDX_W-1:0] bidx_r, bidx_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic              pres_r, pres_nxt;
  logic [7:0]        rx_r, rx_nxt;

  logic              start;
  logic [1:0]        ph;
  logic [TCNT_W-1:0] t;
  logic [BIDX_W-1:0] bi;
  logic [7:0]        sh;
  logic [10:0]       rst_smp;
  logic [TCNT_W-1:0] rst_end;
  logic [7:0]        slot_last;
  logic [7:0]        low_t;
  logic [8:0]        rd_sum;
  logic [7:0]        rd_smp;
  logic              pull, busy, done;

  assign rst_smp   = {1'b0, cfg.reset_low_us} + {1'b0, cfg.presence_wait_us};
  assign rst_end   = {1'b0, rst_smp} + {2'b00, cfg.reset_tail_us};
  // a zero slot length counts as one tick
  assign slot_last = (cfg.slot_us == 8'd0) ? 8'd0 : cfg.slot_us - 8'd1;
  assign rd_sum    = {1'b0, cfg.read_low_us} + {1'b0, cfg.read_sample_us};
  assign rd_smp    = (rd_sum > {1'b0, slot_last}) ? slot_last : rd_sum[7:0];

  always_comb begin
    start = (phase_r == PH_IDLE) && (action != PH_IDLE);
    ph    = start ? action : phase_r;
    t     = start ? '0 : tcnt_r;
    bi    = start ? '0 : bidx_r;
    sh    = start ? ((action == PH_WRITE) ? tx_byte : 8'd0) : shift_r;

    phase_nxt = ph;
    tcnt_nxt  = t;
    bidx_nxt  = bi;
    shift_nxt = sh;
    pres_nxt  = pres_r;
    rx_nxt    = rx_r;
    low_t     = 8'd0;
    pull      = 1'b0;
    busy      = 1'b0;
    done      = 1'b0;

    if (ph == PH_RESET) begin
      busy = 1'b1;
      pull = t < {2'b00, cfg.reset_low_us};
      if (t == {1'b0, rst_smp}) pres_nxt = ~line_in;
      if (t >= rst_end) begin
        done      = 1'b1;
        phase_nxt = PH_IDLE;
        tcnt_nxt  = '0;
      end else begin
        tcnt_nxt = t + 1'b1;
      end
    end else if (ph == PH_WRITE || ph == PH_READ) begin
      busy = 1'b1;
      if (ph == PH_WRITE) begin
        low_t = sh[0] ? cfg.write_one_low_us : cfg.write_zero_low_us;
      end else begin
        low_t = cfg.read_low_us;
        if (t == {4'd0, rd_smp}) shift_nxt = {line_in, sh[7:1]};
      end
      pull = t < {4'd0, low_t};
      if (t >= {4'd0, slot_last}) begin
        tcnt_nxt = '0;
        if (ph == PH_WRITE) shift_nxt = {1'b0, sh[7:1]};
        if (bi == BIDX_W'(BITS_PER_BYTE - 1)) begin
          if (ph == PH_READ) rx_nxt = shift_nxt;
          done      = 1'b1;
          phase_nxt = PH_IDLE;
          bidx_nxt  = '0;
        end else begin
          bidx_nxt = bi + 1'b1;
        end
      end else begin
        tcnt_nxt = t + 1'b1;
      end
    end
  end

  assign res.pull_low = pull;
  assign res.busy_res = busy;
  assign res.done_res = done;
  assign res.presence = pres_nxt;
  assign res.rx_byte  = rx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tcnt_r  <= '0;
      bidx_r  <= '0;
      shift_r <= 8'd0;
      pres_r  <= 1'b0;
      rx_r    <= 8'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      tcnt_r  <= tcnt_nxt;
      bidx_r  <= bidx_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
      rx_r    <= rx_nxt;
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.done_res |=> phase_r == PH_IDLE)
    else $error("phase not idle after done tick");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> tcnt_r == '0 && bidx_r == '0)
    else $error("counters not cleared while idle");

  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    advance && phase_r != PH_IDLE |-> res.busy_res)
    else $error("active phase without busy");

endmodule

FILE: sv/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// one-wire bus master driven by one microsecond tick per input transfer
// ----------------------------------------------------------------------------
//  channel  direction  signals
//  in       slave      in_valid/in_ready, in_action, in_tx_byte, in_line_in
//  out      master     out_valid/out_ready, out_pull_low, out_busy_res,
//                      out_done_res, out_presence, out_rx_byte
//  cfg      apb slave  psel, penable, pwrite, paddr, pwdata, prdata, pready
//
//  one tick per clock sustained while the output is not stalled; a tick goes
//  from input register, then slot sequencer, into the output register
//  synchronous active-low reset restores the timing registers and idles
//  a stalled output holds the input register, which then backs up in_ready
// ----------------------------------------------------------------------------
module one_wire_bus_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_line_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_pull_low,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_presence,
  output logic [7:0]  out_rx_byte,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ow_pkg::*;

  logic       in_vld_r;
  logic [1:0] act_r;
  logic [7:0] tx_r;
  logic       line_r;
  logic       out_vld_r;
  ow_result_t res_r;
  ow_result_t res;
  ow_cfg_t    cfg;
  logic       adv;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  ow_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ow_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (adv),
    .action  (act_r),
    .tx_byte (tx_r),
    .line_in (line_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      act_r  <= in_action;
      tx_r   <= in_tx_byte;
      line_r <= in_line_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // result register, loaded with each processed tick
  always_ff @(posedge clk) begin
    if (adv) res_r <= res;
  end

  assign out_valid    = out_vld_r;
  assign out_pull_low = res_r.pull_low;
  assign out_busy_res = res_r.busy_res;
  assign out_done_res = res_r.done_res;
  assign out_presence = res_r.presence;
  assign out_rx_byte  = res_r.rx_byte;

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(act_r) && $stable(tx_r))
    else $error("pending tick lost while output stalled");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("processed tick produced no result");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.done_res |-> res_r.busy_res)
    else $error("done without busy");

endmodule
